/* rtl/table_interp_diffusion_defines.svh */
// ----------------------------------------------------------------------------
// table_interp_diffusion_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TABLE_INTERP_DIFFUSION_DEFINES_SVH
`define TABLE_INTERP_DIFFUSION_DEFINES_SVH

// same-cycle implication
`define TID_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tid_pkg.sv */
// ----------------------------------------------------------------------------
// tid_pkg
// Types, constants and codes for the table interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package tid_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam logic [6:0]  NUM_POINTS_RST = 7'd2;
  localparam logic [15:0] SCALE_RST      = 16'd2061;

  // register map (index = paddr[2])
  localparam logic REG_NUM_POINTS = 1'b0;
  localparam logic REG_SCALE      = 1'b1;

  // input actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_INTERP  = 2'd0;
  localparam logic [1:0] STAT_BELOW   = 2'd1;
  localparam logic [1:0] STAT_ABOVE   = 2'd2;
  localparam logic [1:0] STAT_DIVZERO = 2'd3;

  // iterative unit sizing
  localparam int DIV_W     = 62;   // dividend / product width
  localparam int DVS_W     = 18;   // divisor / multiplier width
  localparam int DIV_STEPS = DIV_W;
  localparam int MUL_STEPS = DVS_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic               action;
    logic [5:0]         entry_index;
    logic [16:0]        entry_temperature;
    logic signed [23:0] entry_value;
    logic [16:0]        query_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] diffusion;
    logic [1:0]         status;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [16:0]        temp;
    logic signed [23:0] val;
  } mem_entry_t;

  typedef enum logic [1:0] {
    OP_DIV = 2'b01,
    OP_MUL = 2'b10
  } alu_op_t;

  typedef struct packed {
    logic             go;
    alu_op_t          op;
    logic [DIV_W-1:0] a;
    logic [DVS_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] res;
  } alu_rsp_t;

endpackage

`default_nettype wire

/* rtl/tid_mem.sv */
// ----------------------------------------------------------------------------
// tid_mem
// Table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tid_mem import tid_pkg::*; #(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW    = $clog2(MAX_POINTS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire mem_entry_t    wdata,
  input  wire logic [AW-1:0] raddr,
  output mem_entry_t         rdata
);

  mem_entry_t mem [DEPTH];
  mem_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/tid_alu.sv */
// ----------------------------------------------------------------------------
// tid_alu
// Shared iterative unit: restoring divide (one quotient bit per cycle) and
// shift-add multiply (one multiplier bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module tid_alu import tid_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_cmd_t cmd,
  output alu_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  alu_op_t          op_r, op_nxt;
  logic [DIV_W-1:0] acc_r, acc_nxt;
  logic [DIV_W-1:0] opnd_r, opnd_nxt;
  logic [DVS_W-1:0] b_r, b_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    opnd_nxt = opnd_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, acc_r[DIV_W-1]};
    diff     = {1'b0, shifted} - {2'b00, b_r};

    if (cmd.go && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      b_nxt    = cmd.b;
      rem_nxt  = '0;
      if (cmd.op == OP_MUL) begin
        acc_nxt  = '0;
        opnd_nxt = cmd.a;
        cnt_nxt  = CNT_W'(MUL_STEPS - 1);
      end else begin
        acc_nxt  = cmd.a;
        cnt_nxt  = CNT_W'(DIV_STEPS - 1);
      end
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_nxt = {acc_r[DIV_W-2:0], 1'b0} + (b_r[DVS_W-1] ? opnd_r : '0);
          b_nxt   = {b_r[DVS_W-2:0], 1'b0};
        end
        OP_DIV: begin
          if (!diff[DVS_W+1]) begin
            rem_nxt = diff[DVS_W-1:0];
            acc_nxt = {acc_r[DIV_W-2:0], 1'b1};
          end else begin
            rem_nxt = shifted[DVS_W-1:0];
            acc_nxt = {acc_r[DIV_W-2:0], 1'b0};
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_DIV;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    opnd_r <= opnd_nxt;
    b_r    <= b_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp = '{done: done_r, res: acc_r};

endmodule

`default_nettype wire

/* rtl/table_interp_diffusion.sv */
// ----------------------------------------------------------------------------
// table_interp_diffusion
// Piecewise linear table lookup with linear extrapolation off either end,
// scaled by scale_factor / T, saturated to signed Q16.16.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | start & !busy          | in_item   (in_item_t)
//  result   | out_valid, 1-cycle     | out_item  (out_item_t)
//  config   | psel&penable&pwrite    | paddr[2] selects, pwdata
//
//  A write item is stored at the accept edge and busy stays low.
//  A query holds busy through S_RD_LAST, S_CLASS, S_WALK inside the table or
//  S_FETCH when extrapolating, S_MUL1, S_MUL2 and S_CHECK, then, unless a
//  divisor is zero, the passes S_DIV1, S_MUL3 and S_DIV2 of the shared
//  divide/multiply unit. The walk does one read a cycle; the unit, one bit a cycle.
//  The result strobe comes in the same cycle that busy falls.
//  Reset (rst_n low, synchronous) loads num_points=2, scale_factor=2061;
//  the table itself is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module table_interp_diffusion import tid_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  // result channel
  output logic             out_valid,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  // one-hot sequencer
  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_RD_LAST = 11'b000_0000_0010,
    S_CLASS   = 11'b000_0000_0100,
    S_WALK    = 11'b000_0000_1000,
    S_FETCH   = 11'b000_0001_0000,
    S_MUL1    = 11'b000_0010_0000,
    S_MUL2    = 11'b000_0100_0000,
    S_CHECK   = 11'b000_1000_0000,
    S_DIV1    = 11'b001_0000_0000,
    S_MUL3    = 11'b010_0000_0000,
    S_DIV2    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [6:0]  num_points_r;
  logic [15:0] scale_r;

  // query working registers
  logic [16:0]        t_r, t_nxt;
  logic [16:0]        ta_r, ta_nxt, tb_r, tb_nxt;
  logic signed [23:0] va_r, va_nxt, vb_r, vb_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [45:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;

  // result registers
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // table
  logic          mem_we;
  logic [AW-1:0] mem_waddr, raddr;
  mem_entry_t    mem_wdata, rdata;

  alu_cmd_t alu_cmd;
  alu_rsp_t alu_rsp;

  // effective point count, clamped to 2..MAX_POINTS
  logic [AW:0]   n_eff;
  logic [AW-1:0] last;

  always_comb begin
    if (num_points_r < 7'd2) begin
      n_eff = (AW+1)'(2);
    end else if (int'(num_points_r) > MAX_POINTS) begin
      n_eff = (AW+1)'(MAX_POINTS);
    end else begin
      n_eff = (AW+1)'(num_points_r);
    end
  end

  assign last = AW'(n_eff - 1'b1);

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUM_POINTS_RST;
      scale_r      <= SCALE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_NUM_POINTS: num_points_r <= pwdata[6:0];
        REG_SCALE:      scale_r      <= pwdata[15:0];
        default:        num_points_r <= num_points_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SCALE) ? {16'd0, scale_r} : {25'd0, num_points_r};

  // ---------------------------------------------------------------- table writes
  // writes land directly at the accept edge; indexes past the table are dropped
  assign mem_we    = start && !busy && (in_item.action == ACT_WRITE)
                     && (int'(in_item.entry_index) < MAX_POINTS);
  assign mem_waddr = AW'(in_item.entry_index);
  assign mem_wdata = '{temp: in_item.entry_temperature, val: in_item.entry_value};

  tid_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tid_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .rsp   (alu_rsp)
  );

  // ---------------------------------------------------------------- datapath
  // segment width, sign-correct for a non-ascending table
  logic signed [17:0] d_s, absd;
  logic signed [17:0] mx;     // multiplier operand (temperature difference)
  logic signed [24:0] my;     // multiplicand operand (value or value slope)
  logic signed [42:0] prod;
  logic [45:0]        mag;
  logic [DIV_W-1:0]   rnd_res;
  logic [DIV_W-1:0]   rm;

  assign d_s  = $signed({1'b0, tb_r}) - $signed({1'b0, ta_r});
  assign absd = d_s[17] ? -d_s : d_s;
  assign mag  = acc_r[45] ? 46'(-acc_r) : 46'(acc_r);

  // Inside:  (T-ta)*vb + (tb-T)*va
  // Below:   d*va     + (T-ta)*(vb-va)
  // Above:   d*vb     + (T-tb)*(vb-va)
  always_comb begin
    mx = '0;
    my = '0;
    if (state_r == S_MUL1) begin
      if (mode_r == STAT_INTERP) begin
        mx = $signed({1'b0, t_r}) - $signed({1'b0, ta_r});
        my = 25'(vb_r);
      end else begin
        mx = d_s;
        my = (mode_r == STAT_BELOW) ? 25'(va_r) : 25'(vb_r);
      end
    end else begin
      case (mode_r)
        STAT_INTERP: begin
          mx = $signed({1'b0, tb_r}) - $signed({1'b0, t_r});
          my = 25'(va_r);
        end
        STAT_BELOW: begin
          mx = $signed({1'b0, t_r}) - $signed({1'b0, ta_r});
          my = 25'(vb_r) - 25'(va_r);
        end
        default: begin
          mx = $signed({1'b0, t_r}) - $signed({1'b0, tb_r});
          my = 25'(vb_r) - 25'(va_r);
        end
      endcase
    end
  end

  assign prod    = mx * my;
  assign rnd_res = alu_rsp.res + DIV_W'(t_r >> 1);
  assign rm      = alu_rsp.res;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    raddr         = '0;
    alu_cmd       = '{go: 1'b0, op: OP_DIV, a: '0, b: '0};

    case (state_r)
      S_IDLE: begin
        if (start && in_item.action == ACT_QUERY) begin
          t_nxt     = in_item.query_temperature;
          raddr     = '0;
          state_nxt = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        // entry 0 on the read port
        ta_nxt    = rdata.temp;
        va_nxt    = rdata.val;
        raddr     = last;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        // last entry on the read port
        if (t_r < ta_r) begin
          mode_nxt  = STAT_BELOW;
          raddr     = AW'(1);
          state_nxt = S_FETCH;
        end else if (t_r > rdata.temp) begin
          mode_nxt  = STAT_ABOVE;
          tb_nxt    = rdata.temp;
          vb_nxt    = rdata.val;
          raddr     = last - 1'b1;
          state_nxt = S_FETCH;
        end else begin
          mode_nxt  = STAT_INTERP;
          idx_nxt   = '0;
          raddr     = AW'(1);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // entry idx+1 on the read port
        if ((idx_r < last - 1'b1) && (t_r > rdata.temp)) begin
          ta_nxt  = rdata.temp;
          va_nxt  = rdata.val;
          idx_nxt = idx_r + 1'b1;
          raddr   = idx_r + AW'(2);
        end else begin
          tb_nxt    = rdata.temp;
          vb_nxt    = rdata.val;
          state_nxt = S_MUL1;
        end
      end
      S_FETCH: begin
        if (mode_r == STAT_BELOW) begin
          tb_nxt = rdata.temp;
          vb_nxt = rdata.val;
        end else begin
          ta_nxt = rdata.temp;
          va_nxt = rdata.val;
        end
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        acc_nxt   = 46'(prod);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = acc_r + 46'(prod);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (d_s == '0 || t_r == '0) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{diffusion: '0, status: STAT_DIVZERO, saturated: 1'b0};
          state_nxt     = S_IDLE;
        end else begin
          // round to nearest, ties away: divide |N| + |d|/2 by |d|
          neg_nxt   = acc_r[45] ^ d_s[17];
          alu_cmd   = '{go: 1'b1, op: OP_DIV,
                        a: DIV_W'(mag) + DIV_W'(absd[16:1]),
                        b: DVS_W'(absd)};
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (alu_rsp.done) begin
          alu_cmd   = '{go: 1'b1, op: OP_MUL, a: alu_rsp.res, b: DVS_W'(scale_r)};
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: begin
        if (alu_rsp.done) begin
          alu_cmd   = '{go: 1'b1, op: OP_DIV, a: rnd_res, b: DVS_W'(t_r)};
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (alu_rsp.done) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.status    = mode_r;
          out_item_nxt.saturated = 1'b0;
          if (neg_r) begin
            if (rm > DIV_W'(64'h8000_0000)) begin
              out_item_nxt.diffusion = 32'sh8000_0000;
              out_item_nxt.saturated = 1'b1;
            end else begin
              out_item_nxt.diffusion = -$signed(rm[31:0]);
            end
          end else begin
            if (rm > DIV_W'(64'h7FFF_FFFF)) begin
              out_item_nxt.diffusion = 32'sh7FFF_FFFF;
              out_item_nxt.saturated = 1'b1;
            end else begin
              out_item_nxt.diffusion = $signed(rm[31:0]);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    ta_r       <= ta_nxt;
    tb_r       <= tb_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    mode_r     <= mode_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* rtl/tid_checker.sv */
// ----------------------------------------------------------------------------
// tid_checker
// Port-level checks on the table interpolation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_interp_diffusion_defines.svh"

module tid_checker import tid_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  `TID_ASSERT_NEXT(a_query_goes_busy, clk, rst_n, start && !busy && in_item.action == ACT_QUERY, busy, "query accepted but block not busy")

  `TID_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, out_valid, !out_valid, "two result transfers in a row")

  `TID_ASSERT_IMPL(a_result_frees, clk, rst_n, out_valid, !busy, "busy while a result is shown")

  `TID_ASSERT_IMPL(a_divzero_clean, clk, rst_n, out_valid && out_item.status == STAT_DIVZERO, out_item.diffusion == 32'sd0 && !out_item.saturated, "division by zero result not cleared")

  `TID_ASSERT_IMPL(a_sat_at_rail, clk, rst_n, out_valid && out_item.saturated, out_item.diffusion == 32'sh7FFF_FFFF || out_item.diffusion == 32'sh8000_0000, "saturated result not at a rail")

endmodule

bind table_interp_diffusion tid_checker u_tid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
